[design/hs_pkg.sv]
// Shared constants and the result record for the histogram statistics block.
// No dependencies; every other design file imports this package.
package hs_pkg;

    localparam int IN_COUNT_W  = 32;  // width of the bin count field on the input channel
    localparam int IDX_OUT_W   = 8;   // width of the bin index fields of a result
    localparam int MEAN_W      = 24;  // width of the Q16 mean field
    localparam int MEAN_FRAC_W = 16;  // fraction bits of the mean
    localparam int MED_W       = 9;   // width of the doubled median field
    localparam int QUEUE_DEPTH = 4;   // entries between front and back, a power of two

    typedef struct packed {
        logic [IDX_OUT_W-1:0] min_value;
        logic [IDX_OUT_W-1:0] max_value;
        logic [MEAN_W-1:0]    mean_q16;
        logic [MED_W-1:0]     median_doubled;
        logic [IDX_OUT_W-1:0] mode_value;
        logic                 empty_res;
    } t_result;

endpackage

[design/hs_if.sv]
// Valid/ready channel interfaces for bin beats in and result beats out.
// Depends on hs_pkg for the field widths.
interface hs_in_if import hs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [IN_COUNT_W-1:0] bin_count;
    logic                  last;

    modport source (output valid, bin_count, last, input ready);
    modport sink   (input valid, bin_count, last, output ready);
endinterface

interface hs_res_if import hs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [IDX_OUT_W-1:0] min_value;
    logic [IDX_OUT_W-1:0] max_value;
    logic [MEAN_W-1:0]    mean_q16;
    logic [MED_W-1:0]     median_doubled;
    logic [IDX_OUT_W-1:0] mode_value;
    logic                 empty_res;

    modport source (output valid, min_value, max_value, mean_q16, median_doubled,
                    mode_value, empty_res, input ready);
    modport sink   (input valid, min_value, max_value, mean_q16, median_doubled,
                    mode_value, empty_res, output ready);
endinterface

[design/hs_front.sv]
// Front end: accepts bin beats, masks the count, tags each bin with its index
// and marks the bin that closes a histogram. Depends on hs_pkg and hs_in_if.
module hs_front import hs_pkg::*; #(
    parameter int BINS       = 256,
    parameter int COUNT_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    hs_in_if.sink                                 i_in,
    input  logic                                  i_q_full,
    output logic                                  o_push,
    output logic [((COUNT_BITS < IN_COUNT_W) ? COUNT_BITS : IN_COUNT_W)
                  + ((BINS > 1) ? $clog2(BINS) : 1):0] o_item
);
    localparam int IDX_W = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int CW    = (COUNT_BITS < IN_COUNT_W) ? COUNT_BITS : IN_COUNT_W;

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             w_end;

    // A histogram closes on the last flag or on its final bin.
    assign w_end      = i_in.last || (r_idx == IDX_W'(BINS - 1));
    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;
    assign o_item     = {w_end, r_idx, i_in.bin_count[CW-1:0]};

    always_comb begin
        n_idx = r_idx;
        if (o_push) begin
            n_idx = w_end ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

[design/hs_queue.sv]
// Short FIFO that decouples the front end from the back end.
// Depends on hs_pkg for its depth.
module hs_queue import hs_pkg::*; #(
    parameter int W = 41
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_pop
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [W-1:0]  r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_count == (PW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers wrap by overflow since the depth is a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[design/hs_back.sv]
// Back end: accumulates bins into totals and the cumulative count memory, then
// runs the mean division and median scan and holds the result beat.
// Depends on hs_pkg and hs_res_if.
module hs_back import hs_pkg::*; #(
    parameter int BINS       = 256,
    parameter int COUNT_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_q_valid,
    input  logic [((COUNT_BITS < IN_COUNT_W) ? COUNT_BITS : IN_COUNT_W)
                  + ((BINS > 1) ? $clog2(BINS) : 1):0] i_q_item,
    output logic                                  o_q_pop,
    hs_res_if.source                              o_res
);
    localparam int IDX_W  = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int CW     = (COUNT_BITS < IN_COUNT_W) ? COUNT_BITS : IN_COUNT_W;
    localparam int TS_W   = CW + IDX_W;
    localparam int WS_W   = CW + 2 * IDX_W;
    localparam int PR_W   = CW + IDX_W;
    localparam int DW     = WS_W + MEAN_FRAC_W;
    localparam int DCW    = $clog2(DW + 1);
    localparam int IW_OUT = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;
    localparam int MSW    = (IDX_W + 1 > MED_W) ? IDX_W + 1 : MED_W;

    typedef enum logic [2:0] {
        ST_ACCUM  = 3'b001,
        ST_FINISH = 3'b010,
        ST_DONE   = 3'b100
    } t_state;

    t_state           r_state;

    // Accumulators of the open histogram.
    logic [TS_W-1:0]  r_ts;
    logic [WS_W-1:0]  r_ws;
    logic             r_found;
    logic [IDX_W-1:0] r_first;
    logic [IDX_W-1:0] r_lastnz;
    logic [IDX_W-1:0] r_best;
    logic [CW-1:0]    r_bestc;
    logic [IDX_W-1:0] r_top;

    logic [TS_W-1:0]  r_cum [BINS];

    // Mean divider.
    logic [DW-1:0]    r_dvd;
    logic [TS_W-1:0]  r_rem;
    logic [MEAN_W-1:0] r_quo;
    logic [DCW-1:0]   r_dcnt;

    // Median scan.
    logic [IDX_W-1:0] r_rd_addr;
    logic [IDX_W-1:0] r_rd_tag;
    logic [TS_W-1:0]  r_rd_data;
    logic             r_rd_pend;
    logic             r_issue_done;
    logic             r_f1;
    logic             r_f2;
    logic [IDX_W-1:0] r_m1;
    logic [IDX_W-1:0] r_m2;

    t_result          r_out;
    logic             r_out_valid;

    logic [CW-1:0]    w_cnt;
    logic [IDX_W-1:0] w_idx;
    logic             w_end;
    logic             w_pop;
    logic [PR_W-1:0]  w_prod;
    logic [TS_W-1:0]  w_ts_n;
    logic [WS_W-1:0]  w_ws_n;
    logic [TS_W:0]    w_trial;
    logic [TS_W:0]    w_diff;
    logic             w_ge;
    logic [TS_W:0]    w_ts_p1;
    logic [TS_W:0]    w_ts_p2;
    logic [TS_W-1:0]  w_t1;
    logic [TS_W-1:0]  w_t2;
    logic             w_issue;
    logic             w_scan_done;
    logic             w_div_done;
    logic             w_load;
    logic [IDX_W-1:0] w_m1;
    logic [IDX_W-1:0] w_m2;
    logic [MSW-1:0]   w_msum;
    logic [IW_OUT-1:0] w_min;
    logic [IW_OUT-1:0] w_max;
    logic [IW_OUT-1:0] w_mode;
    t_result          w_res;

    assign w_cnt = i_q_item[CW-1:0];
    assign w_idx = i_q_item[CW +: IDX_W];
    assign w_end = i_q_item[CW + IDX_W];

    assign w_pop   = (r_state == ST_ACCUM) && i_q_valid;
    assign o_q_pop = w_pop;

    assign w_prod = PR_W'(w_idx) * PR_W'(w_cnt);
    assign w_ts_n = r_ts + TS_W'(w_cnt);
    assign w_ws_n = r_ws + WS_W'(w_prod);

    // Restoring division of the weighted sum, shifted by the fraction bits, by the total.
    assign w_trial    = {r_rem, r_dvd[DW-1]};
    assign w_diff     = w_trial - {1'b0, r_ts};
    assign w_ge       = (w_trial >= {1'b0, r_ts});
    assign w_div_done = (r_dcnt == '0);

    assign w_ts_p1 = {1'b0, r_ts} + (TS_W + 1)'(1);
    assign w_ts_p2 = {1'b0, r_ts} + (TS_W + 1)'(2);
    assign w_t1    = w_ts_p1[TS_W:1];
    assign w_t2    = w_ts_p2[TS_W:1];

    // The cumulative counts rise monotonically, so one pass finds both middle bins.
    assign w_issue     = (r_state == ST_FINISH) && !r_issue_done && !r_f2;
    assign w_scan_done = r_f2 || (r_issue_done && !r_rd_pend);

    assign w_load = (r_state == ST_DONE) && (!r_out_valid || o_res.ready);

    assign w_m1   = r_f1 ? r_m1 : r_top;
    assign w_m2   = r_f2 ? r_m2 : r_top;
    assign w_msum = MSW'(w_m1) + MSW'(w_m2);
    assign w_min  = IW_OUT'(r_first);
    assign w_max  = IW_OUT'(r_lastnz);
    assign w_mode = IW_OUT'(r_best);

    always_comb begin
        w_res = '0;
        if (r_ts == '0) begin
            w_res.empty_res = 1'b1;
        end else begin
            w_res.min_value      = w_min[IDX_OUT_W-1:0];
            w_res.max_value      = w_max[IDX_OUT_W-1:0];
            w_res.mean_q16       = r_quo;
            w_res.median_doubled = w_msum[MED_W-1:0];
            w_res.mode_value     = w_mode[IDX_OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_cum[w_idx] <= w_ts_n;
        end
        r_rd_data <= r_cum[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_ACCUM;
            r_ts         <= '0;
            r_ws         <= '0;
            r_found      <= 1'b0;
            r_first      <= '0;
            r_lastnz     <= '0;
            r_best       <= '0;
            r_bestc      <= '0;
            r_top        <= '0;
            r_dvd        <= '0;
            r_rem        <= '0;
            r_quo        <= '0;
            r_dcnt       <= '0;
            r_rd_addr    <= '0;
            r_rd_tag     <= '0;
            r_rd_pend    <= 1'b0;
            r_issue_done <= 1'b0;
            r_f1         <= 1'b0;
            r_f2         <= 1'b0;
            r_m1         <= '0;
            r_m2         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_ACCUM: begin
                    if (w_pop) begin
                        r_ts <= w_ts_n;
                        r_ws <= w_ws_n;
                        if (w_cnt != '0) begin
                            if (!r_found) begin
                                r_first <= w_idx;
                                r_found <= 1'b1;
                            end
                            r_lastnz <= w_idx;
                        end
                        if (w_cnt > r_bestc) begin
                            r_bestc <= w_cnt;
                            r_best  <= w_idx;
                        end
                        if (w_end) begin
                            r_top        <= w_idx;
                            r_dvd        <= {w_ws_n, MEAN_FRAC_W'(0)};
                            r_rem        <= '0;
                            r_quo        <= '0;
                            r_rd_addr    <= '0;
                            r_rd_pend    <= 1'b0;
                            r_issue_done <= 1'b0;
                            r_f1         <= 1'b0;
                            r_f2         <= 1'b0;
                            if (w_ts_n == '0) begin
                                r_dcnt  <= '0;
                                r_state <= ST_DONE;
                            end else begin
                                r_dcnt  <= DCW'(DW);
                                r_state <= ST_FINISH;
                            end
                        end
                    end
                end
                ST_FINISH: begin
                    if (!w_div_done) begin
                        r_rem  <= w_ge ? w_diff[TS_W-1:0] : w_trial[TS_W-1:0];
                        r_quo  <= {r_quo[MEAN_W-2:0], w_ge};
                        r_dvd  <= {r_dvd[DW-2:0], 1'b0};
                        r_dcnt <= r_dcnt - 1'b1;
                    end
                    r_rd_pend <= w_issue;
                    r_rd_tag  <= r_rd_addr;
                    if (w_issue) begin
                        if (r_rd_addr == r_top) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_rd_addr <= r_rd_addr + 1'b1;
                        end
                    end
                    if (r_rd_pend) begin
                        if (!r_f1 && (r_rd_data >= w_t1)) begin
                            r_f1 <= 1'b1;
                            r_m1 <= r_rd_tag;
                        end
                        if (!r_f2 && (r_rd_data >= w_t2)) begin
                            r_f2 <= 1'b1;
                            r_m2 <= r_rd_tag;
                        end
                    end
                    if (w_scan_done && w_div_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_ts     <= '0;
                        r_ws     <= '0;
                        r_found  <= 1'b0;
                        r_first  <= '0;
                        r_lastnz <= '0;
                        r_best   <= '0;
                        r_bestc  <= '0;
                        r_state  <= ST_ACCUM;
                    end
                end
                default: begin
                    r_state <= ST_ACCUM;
                end
            endcase
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.min_value      = r_out.min_value;
    assign o_res.max_value      = r_out.max_value;
    assign o_res.mean_q16       = r_out.mean_q16;
    assign o_res.median_doubled = r_out.median_doubled;
    assign o_res.mode_value     = r_out.mode_value;
    assign o_res.empty_res      = r_out.empty_res;

endmodule

[design/histogram_statistics_core.sv]
// Histogram statistics core: min, max, Q16 mean, doubled median and mode.
// Depends on hs_pkg, hs_if, hs_front, hs_queue and hs_back.
//
// Bin counts arrive on i_in, one beat per bin in index order from zero; the
// beat with last set, or the BINS-th beat, closes the histogram. Each closed
// histogram yields one beat on o_res.
// Bins are accepted one per cycle into a four-entry queue while it is not full;
// the back end drains it one bin per cycle while accumulating. After the closing
// bin the back end finishes with the bit-serial mean divider and the median scan
// of the cumulative count memory, one read per cycle and stopping once the upper
// middle bin is found, running side by side. An empty histogram skips the
// finishing and goes straight to its result. While the back end finishes, the
// queue keeps taking bins until it is full, then ready drops.
// A stalled result is held in the output register; the next histogram can be
// accumulated meanwhile, and its result waits until the held beat is taken.
// Synchronous reset clears all control state; the memory needs no clearing.
module histogram_statistics_core import hs_pkg::*; #(
    parameter int BINS       = 256,
    parameter int COUNT_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hs_in_if.sink    i_in,
    hs_res_if.source o_res
);
    localparam int IDX_W  = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int CW     = (COUNT_BITS < IN_COUNT_W) ? COUNT_BITS : IN_COUNT_W;
    localparam int ITEM_W = CW + IDX_W + 1;

    logic              w_push;
    logic              w_full;
    logic [ITEM_W-1:0] w_push_item;
    logic              w_q_valid;
    logic [ITEM_W-1:0] w_q_item;
    logic              w_pop;

    hs_front #(
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_item   (w_push_item)
    );

    hs_queue #(
        .W (ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_item),
        .i_pop   (w_pop)
    );

    hs_back #(
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_pop),
        .o_res     (o_res)
    );

endmodule

[design/hs_checker.sv]
// Port-level checks on the result channel of the histogram statistics core,
// and the bind that attaches them. Depends on hs_pkg.
module hs_checker import hs_pkg::*; #(
    parameter int BINS = 256
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [IDX_OUT_W-1:0] i_min_value,
    input logic [IDX_OUT_W-1:0] i_max_value,
    input logic [MEAN_W-1:0]    i_mean_q16,
    input logic [MED_W-1:0]     i_median_doubled,
    input logic [IDX_OUT_W-1:0] i_mode_value,
    input logic                 i_empty_res
);
    localparam bit INDEX_FITS = (BINS <= (1 << IDX_OUT_W));

    // A result beat that is not taken stays on the port unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_min_value,
        i_max_value, i_mean_q16, i_median_doubled, i_mode_value, i_empty_res}))
        else $error("result beat changed while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_empty_res |-> i_min_value == '0 && i_max_value == '0 &&
        i_mean_q16 == '0 && i_median_doubled == '0 && i_mode_value == '0)
        else $error("empty result carries nonzero fields");

    // Mode and integer part of the mean lie between the occupied extremes.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        INDEX_FITS && i_out_valid && !i_empty_res |->
        i_min_value <= i_max_value && i_mode_value >= i_min_value &&
        i_mode_value <= i_max_value &&
        i_mean_q16[MEAN_W-1:MEAN_FRAC_W] >= i_min_value &&
        i_mean_q16[MEAN_W-1:MEAN_FRAC_W] <= i_max_value)
        else $error("result indexes out of order");

    a_median: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        INDEX_FITS && i_out_valid && !i_empty_res |->
        i_median_doubled >= {i_min_value, 1'b0} &&
        i_median_doubled <= {i_max_value, 1'b0})
        else $error("median outside occupied range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind histogram_statistics_core hs_checker #(.BINS(BINS)) u_hs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_min_value      (o_res.min_value),
    .i_max_value      (o_res.max_value),
    .i_mean_q16       (o_res.mean_q16),
    .i_median_doubled (o_res.median_doubled),
    .i_mode_value     (o_res.mode_value),
    .i_empty_res      (o_res.empty_res)
);

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for histogram_statistics_core: streams histograms of bin counts
// and compares each min/max/mean/median/mode beat with a predictor kept alongside.
// Depends on hs_pkg, the hs_in_if/hs_res_if interfaces and the core itself.
module tb_top;
    import hs_pkg::*;

    localparam int HS_BINS       = 256;
    localparam int HS_COUNT_BITS = 32;
    localparam logic [IN_COUNT_W-1:0] COUNT_MASK =
        IN_COUNT_W'((64'd1 << HS_COUNT_BITS) - 1);
    localparam int ITEM_TARGET   = 1850;
    localparam int LONG_HOLD     = 1500;   // receiver hold-off during the pressure test
    localparam int DRAIN_CYCLES  = 300;    // longest back-end finish plus margin
    localparam int IDLE_LIMIT    = 20000;  // cycles with no beat on either side
    localparam int REPORT_MAX    = 10;

    typedef enum int {
        PROF_ZERO,
        PROF_SPARSE,
        PROF_SMALL,
        PROF_WIDE,
        PROF_MAX
    } t_profile;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hs_in_if  bin_if ();
    hs_res_if res_if ();

    histogram_statistics_core #(
        .BINS       (HS_BINS),
        .COUNT_BITS (HS_COUNT_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (bin_if),
        .o_res   (res_if)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state for the histogram currently being accumulated.
    logic [39:0] cum_mem [HS_BINS];
    int unsigned cur_bin;
    logic [39:0] run_total;
    logic [47:0] run_wsum;
    int unsigned first_hit;
    int unsigned last_hit;
    int unsigned mode_bin;
    logic [31:0] mode_count;

    t_result pending_stats [$];

    int  fail_count     = 0;
    int  beats_sent     = 0;
    int  hist_closed    = 0;
    int  hist_empty     = 0;
    int  hist_by_count  = 0;
    int  results_seen   = 0;
    bit  tx_steady      = 1'b0;
    bit  rx_steady      = 1'b0;
    bit  hold_request   = 1'b0;

    function automatic void reset_stats();
        cur_bin    = 0;
        run_total  = '0;
        run_wsum   = '0;
        first_hit  = HS_BINS;
        last_hit   = 0;
        mode_bin   = 0;
        mode_count = '0;
    endfunction

    function automatic int unsigned find_rank_bin(int unsigned top, logic [63:0] target);
        for (int unsigned i = 0; i <= top; i++) begin
            if (64'(cum_mem[i]) >= target)
                return i;
        end
        return top;
    endfunction

    // Folds one accepted bin beat into the running statistics and queues the
    // expected result when the beat closes the histogram.
    function automatic void fold_bin(logic [IN_COUNT_W-1:0] raw, logic lst);
        logic [31:0] cnt;
        int unsigned ix;
        logic [63:0] n, q, r, mean, t1, t2;
        int unsigned m1, m2;
        t_result res;
        cnt = raw & COUNT_MASK;
        ix  = (cur_bin >= HS_BINS) ? HS_BINS - 1 : cur_bin;
        run_total  = run_total + 40'(cnt);
        run_wsum   = run_wsum + 48'(ix) * 48'(cnt);
        cum_mem[ix] = run_total;
        if (cnt != 0) begin
            if (first_hit >= HS_BINS)
                first_hit = ix;
            last_hit = ix;
        end
        if (cnt > mode_count) begin
            mode_count = cnt;
            mode_bin   = ix;
        end
        if (!lst && ix < HS_BINS - 1) begin
            cur_bin = ix + 1;
            return;
        end
        hist_closed++;
        if (!lst)
            hist_by_count++;
        n   = 64'(run_total);
        res = '0;
        if (n == 0) begin
            res.empty_res = 1'b1;
            hist_empty++;
        end else begin
            q    = 64'(run_wsum) / n;
            r    = 64'(run_wsum) % n;
            mean = (q << MEAN_FRAC_W) + ((r << MEAN_FRAC_W) / n);
            t1   = (n + 1) / 2;
            t2   = (n + 2) / 2;
            m1   = find_rank_bin(ix, t1);
            m2   = find_rank_bin(ix, t2);
            res.min_value      = IDX_OUT_W'(first_hit);
            res.max_value      = IDX_OUT_W'(last_hit);
            res.mean_q16       = MEAN_W'(mean);
            res.median_doubled = MED_W'(m1 + m2);
            res.mode_value     = IDX_OUT_W'(mode_bin);
        end
        pending_stats.push_back(res);
        reset_stats();
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else if (pick < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [IN_COUNT_W-1:0] draw_count(t_profile prof);
        case (prof)
            PROF_ZERO:   return '0;
            PROF_SPARSE: return ($urandom_range(0, 99) < 80) ? '0 : $urandom_range(1, 20);
            PROF_SMALL:  return $urandom_range(0, 6);
            PROF_WIDE:   return ($urandom_range(0, 9) == 0) ? '0 : $urandom();
            default:     return ($urandom_range(0, 1) == 0) ? '1 : $urandom();
        endcase
    endfunction

    // Offers one bin beat and returns right after the edge at which it was taken.
    // valid stays high so that a back-to-back beat needs no second assignment.
    task automatic send_bin(input logic [IN_COUNT_W-1:0] cnt, input logic lst);
        int gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            bin_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        bin_if.valid     <= 1'b1;
        bin_if.bin_count <= cnt;
        bin_if.last      <= lst;
        do @(posedge i_clk); while (!bin_if.ready);
        fold_bin(cnt, lst);
        beats_sent++;
    endtask

    task automatic send_histogram(input int len, input t_profile prof, input bit close_last);
        for (int i = 0; i < len; i++)
            send_bin(draw_count(prof), close_last && (i == len - 1));
    endtask

    task automatic test_edge_bins();
        send_bin(32'h0000_0000, 1'b1);            // empty single bin
        send_bin(32'hFFFF_FFFF, 1'b1);            // one full-scale bin
        send_bin(32'h0, 1'b0);                    // empty over three bins
        send_bin(32'h0, 1'b0);
        send_bin(32'h0, 1'b1);
        send_bin(32'd1, 1'b0);                    // mode tie, first one wins
        send_bin(32'd0, 1'b0);
        send_bin(32'd5, 1'b0);
        send_bin(32'd5, 1'b0);
        send_bin(32'd2, 1'b1);
        send_bin(32'd0, 1'b0);                    // occupied range inside the histogram
        send_bin(32'd7, 1'b0);
        send_bin(32'd0, 1'b0);
        send_bin(32'd0, 1'b1);
        send_bin(32'hFFFF_FFFF, 1'b0);            // even total split across two bins
        send_bin(32'hFFFF_FFFF, 1'b1);
        send_bin(32'd0, 1'b0);
        send_bin(32'd0, 1'b0);
        send_bin(32'd1, 1'b1);
        send_bin(32'hAAAA_AAAA, 1'b0);
        send_bin(32'h5555_5555, 1'b1);
    endtask

    // Histograms of the full bin count: closed by count alone, or by last on the final bin.
    task automatic test_full_length();
        send_histogram(HS_BINS, PROF_MAX, 1'b0);
        for (int i = 0; i < HS_BINS; i++)
            send_bin('1, 1'b0);
        send_histogram(HS_BINS, PROF_WIDE, 1'b1);
        send_histogram(HS_BINS, PROF_SPARSE, 1'b0);
    endtask

    // Results are held off for a long stretch while bins keep coming with no gaps.
    task automatic test_backpressure();
        hold_request = 1'b1;
        tx_steady    = 1'b1;
        for (int h = 0; h < 4; h++)
            send_histogram($urandom_range(6, 10), PROF_SMALL, 1'b1);
        tx_steady = 1'b0;
    endtask

    task automatic test_random_hists();
        int len;
        int pick;
        t_profile prof;
        while (beats_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                len = $urandom_range(1, 12);
            else if (pick < 97)
                len = $urandom_range(13, 64);
            else
                len = $urandom_range(65, HS_BINS - 1);
            if (len > ITEM_TARGET - beats_sent)
                len = ITEM_TARGET - beats_sent;
            pick = $urandom_range(0, 99);
            if (pick < 6)
                prof = PROF_ZERO;
            else if (pick < 30)
                prof = PROF_SPARSE;
            else if (pick < 60)
                prof = PROF_SMALL;
            else if (pick < 90)
                prof = PROF_WIDE;
            else
                prof = PROF_MAX;
            pick      = $urandom_range(0, 99);
            tx_steady = (pick < 15);
            rx_steady = (pick < 10);
            send_histogram(len, prof, 1'b1);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Result side: checks each taken beat against the oldest expectation, then
    // decides ready for the next cycle.
    initial begin
        int stall_left;
        t_result got;
        t_result want;
        stall_left   = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                got.min_value      = res_if.min_value;
                got.max_value      = res_if.max_value;
                got.mean_q16       = res_if.mean_q16;
                got.median_doubled = res_if.median_doubled;
                got.mode_value     = res_if.mode_value;
                got.empty_res      = res_if.empty_res;
                results_seen++;
                if (pending_stats.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: result beat with nothing expected: min %0d max %0d",
                                 $realtime, got.min_value, got.max_value);
                end else begin
                    want = pending_stats.pop_front();
                    if (got.min_value !== want.min_value ||
                        got.max_value !== want.max_value ||
                        got.mean_q16 !== want.mean_q16 ||
                        got.median_doubled !== want.median_doubled ||
                        got.mode_value !== want.mode_value ||
                        got.empty_res !== want.empty_res) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX) begin
                            $display("%0t: result %0d mismatch", $realtime, results_seen);
                            $display("  expected min %0d max %0d mean %h med2 %0d mode %0d empty %b",
                                     want.min_value, want.max_value, want.mean_q16,
                                     want.median_doubled, want.mode_value, want.empty_res);
                            $display("  actual   min %0d max %0d mean %h med2 %0d mode %0d empty %b",
                                     got.min_value, got.max_value, got.mean_q16,
                                     got.median_doubled, got.mode_value, got.empty_res);
                        end
                    end
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else if (rx_steady) begin
                res_if.ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 70) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= 1'b0;
                stall_left = idle_len();
            end
        end
    end

    // Ends the run if no beat moves on either channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((bin_if.valid && bin_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
                         quiet, pending_stats.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        bin_if.valid     <= 1'b0;
        bin_if.bin_count <= '0;
        bin_if.last      <= 1'b0;
        i_rst_n          <= 1'b0;
        reset_stats();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_bins();
        test_full_length();
        test_backpressure();
        test_random_hists();

        bin_if.valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bin beats forming %0d histograms (%0d empty, %0d closed by bin count).",
                 beats_sent, hist_closed, hist_empty, hist_by_count);
        $display("Checked %0d result beats, %0d failures.", results_seen, fail_count);
        if (fail_count == 0 && pending_stats.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
